FILE: design/atb_pkg.sv
// shared types and constants for the adc to temperature converter
package atb_pkg;

   // default sizes
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int SAMPLE_BITS_DEF = 10;
   localparam int FRAC_BITS_DEF   = 4;

   // fixed field widths
   localparam int TEMP_BITS     = 17;
   localparam int STATUS_BITS   = 2;
   localparam int BASE_BITS     = 8;
   localparam int STEP_BITS     = 4;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 2;

   // register reset values
   localparam int BASE_RESET = -50;
   localparam int STEP_RESET = 1;
   localparam int USED_RESET = 171;

   // register indexes
   localparam logic [REG_IDX_BITS-1:0] REG_BASE = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_STEP = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_USED = 2'd2;

   // request kinds
   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_IN_TABLE = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_COLD     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_HOT      = 2'd2;

   // conversion sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK0,
      ST_CHKN,
      ST_SEARCH,
      ST_BRACKET,
      ST_DIV,
      ST_TEMP
   } atb_state_type;

endpackage

FILE: design/atb_code_ram.sv
// calibration code table, one write and one registered read port
module atb_code_ram #(
   parameter int DEPTH     = atb_pkg::TABLE_DEPTH_DEF,
   parameter int DATA_BITS = atb_pkg::SAMPLE_BITS_DEF,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/adc_to_temperature_bsearch.sv
// adc code to temperature converter: table search, interpolation and csr block
// sequence: a write transaction completes at acceptance; a convert reads the first entry
//   (saturated cold), then the last used entry (saturated hot), else binary searches the
//   table and, when interpolating, runs a divide of FRAC_BITS + 5 quotient bits
// throughput: one transaction at a time; the search does one table read per cycle and
//   the interpolation divide retires one quotient bit per cycle on the shared subtractor
// reset: synchronous active high; clears the sequencer, the result slot and the csrs;
//   the code table is not cleared and needs no clearing pass
module adc_to_temperature_bsearch #(
   parameter int TABLE_DEPTH = atb_pkg::TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS = atb_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = atb_pkg::FRAC_BITS_DEF,
   localparam int IDX_BITS      = $clog2(TABLE_DEPTH),
   localparam int REQ_DATA_BITS = ((IDX_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((atb_pkg::TEMP_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_DATA_BITS-1:0]           req_tdata,  // entry_index, entry_value, sample
   input  logic [0:0]                         req_tuser,  // op
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_DATA_BITS-1:0]           rsp_tdata,  // temperature_q
   output logic [atb_pkg::STATUS_BITS-1:0]    rsp_tuser,  // status
   // csr port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [atb_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [atb_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [atb_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import atb_pkg::*;

   localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1);
   localparam int Q_BITS     = FRAC_BITS + 5;               // quotient bits of the divide
   localparam int NUM_BITS   = SAMPLE_BITS + STEP_BITS + FRAC_BITS;
   localparam int D_BITS     = NUM_BITS + 2;                // rounded dividend
   localparam int ALU_BITS   = SAMPLE_BITS + 2;
   localparam int QCNT_BITS  = $clog2(Q_BITS);
   localparam int T_RAW_BITS = IDX_BITS + FRAC_BITS + 7;
   localparam int T_BITS     = (T_RAW_BITS > TEMP_BITS) ? T_RAW_BITS : TEMP_BITS;

   // ---------------------------------------------------------------------------
   // request fields
   // ---------------------------------------------------------------------------
   logic [IDX_BITS-1:0]    in_index;
   logic [SAMPLE_BITS-1:0] in_value;
   logic [SAMPLE_BITS-1:0] in_sample;
   logic                   in_op;
   logic                   req_accept;

   assign in_index  = req_tdata[IDX_BITS-1:0];
   assign in_value  = req_tdata[IDX_BITS +: SAMPLE_BITS];
   assign in_sample = req_tdata[IDX_BITS + SAMPLE_BITS +: SAMPLE_BITS];
   assign in_op     = req_tuser[0];
   assign req_accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------------------
   // csr registers
   // ---------------------------------------------------------------------------
   logic signed [BASE_BITS-1:0] base_ff, base_in;
   logic [STEP_BITS-1:0]        step_ff, step_in;
   logic [CNT_BITS-1:0]         used_ff, used_in;
   logic                        csr_wr;
   logic [REG_IDX_BITS-1:0]     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1:2];

   always_comb begin
      base_in = base_ff;
      step_in = step_ff;
      used_in = used_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_BASE: base_in = csr_pwdata[BASE_BITS-1:0];
            REG_STEP: step_in = csr_pwdata[STEP_BITS-1:0];
            REG_USED: used_in = csr_pwdata[CNT_BITS-1:0];
            default:  ;  // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_BASE: csr_prdata = CSR_DATA_BITS'(base_ff);
         REG_STEP: csr_prdata = CSR_DATA_BITS'(step_ff);
         REG_USED: csr_prdata = CSR_DATA_BITS'(used_ff);
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_BITS'(BASE_RESET);
         step_ff <= STEP_BITS'(STEP_RESET);
         used_ff <= CNT_BITS'(USED_RESET);
      end else begin
         base_ff <= base_in;
         step_ff <= step_in;
         used_ff <= used_in;
      end
   end

   // ---------------------------------------------------------------------------
   // sequencer and datapath registers
   // ---------------------------------------------------------------------------
   atb_state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [IDX_BITS-1:0]    last_ff, last_in;     // index of the last used entry
   logic [IDX_BITS-1:0]    top_ff, top_in;       // colder bracket end
   logic [IDX_BITS-1:0]    bot_ff, bot_in;       // hotter bracket end
   logic [IDX_BITS-1:0]    mid_ff, mid_in;       // index being read
   logic [SAMPLE_BITS-1:0] ct_ff, ct_in;         // code at top
   logic [SAMPLE_BITS-1:0] cb_ff, cb_in;         // code at bot
   logic [IDX_BITS-1:0]    k_ff, k_in;           // entry whose temperature is the base
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [SAMPLE_BITS:0]   rem_ff, rem_in;       // divide remainder
   logic [SAMPLE_BITS:0]   dvs_ff, dvs_in;       // divisor, twice the bracket span
   logic [Q_BITS-1:0]      quo_ff, quo_in;       // dividend low bits, then the fraction
   logic [QCNT_BITS-1:0]   qcnt_ff, qcnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TEMP_BITS-1:0]   rsp_temp_ff, rsp_temp_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   logic                   rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // ---------------------------------------------------------------------------
   // table memory
   // ---------------------------------------------------------------------------
   logic                   mem_we;
   logic [IDX_BITS-1:0]    rd_addr;
   logic [SAMPLE_BITS-1:0] rd_data;

   atb_code_ram #(
      .DEPTH     (TABLE_DEPTH),
      .DATA_BITS (SAMPLE_BITS)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (in_index),
      .wr_data (in_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------------------
   // shared subtractor: sample against table code during the search,
   // partial remainder against divisor during the divide
   // ---------------------------------------------------------------------------
   logic [ALU_BITS-1:0] alu_a, alu_b;
   logic [ALU_BITS:0]   alu_diff;
   logic                alu_borrow;
   logic                alu_zero;

   always_comb begin
      if (state_ff == ST_DIV) begin
         alu_a = {rem_ff, quo_ff[Q_BITS-1]};
         alu_b = {1'b0, dvs_ff};
      end else begin
         alu_a = {2'b00, sample_ff};
         alu_b = {2'b00, rd_data};
      end
   end

   assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_borrow = alu_diff[ALU_BITS];
   assign alu_zero   = (alu_diff == '0);

   // ---------------------------------------------------------------------------
   // search bracket update and next probe index
   // ---------------------------------------------------------------------------
   logic [IDX_BITS-1:0] nx_top, nx_bot, nx_mid, nx_gap;
   logic [IDX_BITS:0]   nx_sum;
   logic                nx_wide;

   always_comb begin
      case (state_ff)
         ST_CHKN: begin
            nx_top = '0;
            nx_bot = last_ff;
         end
         ST_SEARCH: begin
            // codes fall with temperature: sample below the code moves toward hot
            if (alu_borrow) begin
               nx_top = mid_ff;
               nx_bot = bot_ff;
            end else begin
               nx_top = top_ff;
               nx_bot = mid_ff;
            end
         end
         default: begin
            nx_top = top_ff;
            nx_bot = bot_ff;
         end
      endcase
   end

   assign nx_sum  = {1'b0, nx_top} + {1'b0, nx_bot};
   assign nx_mid  = nx_sum[IDX_BITS:1];
   assign nx_gap  = nx_bot - nx_top;
   assign nx_wide = (nx_gap > IDX_BITS'(1));

   // clamp of the used entry count to the table
   logic [IDX_BITS-1:0] n_last;

   always_comb begin
      if (used_ff < CNT_BITS'(2)) begin
         n_last = IDX_BITS'(1);
      end else if (used_ff > CNT_BITS'(TABLE_DEPTH)) begin
         n_last = IDX_BITS'(TABLE_DEPTH - 1);
      end else begin
         n_last = IDX_BITS'(used_ff - CNT_BITS'(1));
      end
   end

   // ---------------------------------------------------------------------------
   // bracket decision and divide setup
   // frac = (2 * num + den) / (2 * den), num = (ct - s) * step << FRAC_BITS
   // ---------------------------------------------------------------------------
   logic                   br_top_end, br_bot_end, br_interp;
   logic [SAMPLE_BITS-1:0] dif_ts, den;
   logic [NUM_BITS-1:0]    num;
   logic [D_BITS-1:0]      dividend;

   assign br_top_end = (sample_ff >= ct_ff) || (ct_ff <= cb_ff);
   assign br_bot_end = (sample_ff <= cb_ff);
   assign br_interp  = !br_top_end && !br_bot_end;

   assign dif_ts   = ct_ff - sample_ff;
   assign den      = ct_ff - cb_ff;
   assign num      = (NUM_BITS'(dif_ts) * NUM_BITS'(step_ff)) << FRAC_BITS;
   assign dividend = D_BITS'({num, 1'b0}) + D_BITS'(den);

   // ---------------------------------------------------------------------------
   // final temperature: (base + k * step) << FRAC_BITS plus the fraction
   // ---------------------------------------------------------------------------
   logic signed [T_BITS-1:0] t_base, t_k, t_step, t_frac, t_sum;
   logic [TEMP_BITS-1:0]     temp_q;

   assign t_base = T_BITS'(base_ff);
   assign t_k    = signed'(T_BITS'(k_ff));
   assign t_step = signed'(T_BITS'(step_ff));
   assign t_frac = signed'(T_BITS'(quo_ff));
   assign t_sum  = ((t_base + t_k * t_step) <<< FRAC_BITS) + t_frac;
   assign temp_q = t_sum[TEMP_BITS-1:0];

   // ---------------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && in_op == OP_CONVERT) begin
               state_in = ST_CHK0;
            end
         end
         ST_CHK0: begin
            // sample above the first code saturates cold
            state_in = (!alu_borrow && !alu_zero) ? ST_TEMP : ST_CHKN;
         end
         ST_CHKN: begin
            if (alu_borrow) begin
               state_in = ST_TEMP;
            end else if (nx_wide) begin
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_BRACKET;
            end
         end
         ST_SEARCH: begin
            if (alu_zero) begin
               state_in = ST_TEMP;
            end else if (nx_wide) begin
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_BRACKET;
            end
         end
         ST_BRACKET: begin
            state_in = br_interp ? ST_DIV : ST_TEMP;
         end
         ST_DIV: begin
            if (qcnt_ff == '0) begin
               state_in = ST_TEMP;
            end
         end
         ST_TEMP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------
   // sequencer outputs
   // ---------------------------------------------------------------------------
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      mem_we     = req_accept && (in_op == OP_WRITE)
                   && (CNT_BITS'(in_index) < CNT_BITS'(TABLE_DEPTH));
      case (state_ff)
         ST_IDLE:   rd_addr = '0;
         ST_CHK0:   rd_addr = last_ff;
         ST_CHKN:   rd_addr = nx_mid;
         ST_SEARCH: rd_addr = nx_mid;
         default:   rd_addr = mid_ff;
      endcase
   end

   // ---------------------------------------------------------------------------
   // datapath next values
   // ---------------------------------------------------------------------------
   always_comb begin
      sample_in     = sample_ff;
      last_in       = last_ff;
      top_in        = top_ff;
      bot_in        = bot_ff;
      mid_in        = mid_ff;
      ct_in         = ct_ff;
      cb_in         = cb_ff;
      k_in          = k_ff;
      status_in     = status_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      quo_in        = quo_ff;
      qcnt_in       = qcnt_ff;
      rsp_temp_in   = rsp_temp_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               sample_in = in_sample;
               last_in   = n_last;
               quo_in    = '0;
               status_in = STATUS_IN_TABLE;
            end
         end
         ST_CHK0: begin
            ct_in = rd_data;
            k_in  = '0;
            if (!alu_borrow && !alu_zero) begin
               status_in = STATUS_COLD;
            end
         end
         ST_CHKN: begin
            cb_in  = rd_data;
            top_in = nx_top;
            bot_in = nx_bot;
            mid_in = nx_mid;
            if (alu_borrow) begin
               k_in      = last_ff;
               status_in = STATUS_HOT;
            end
         end
         ST_SEARCH: begin
            top_in = nx_top;
            bot_in = nx_bot;
            mid_in = nx_mid;
            if (alu_zero) begin
               k_in = mid_ff;       // exact hit
            end else if (alu_borrow) begin
               ct_in = rd_data;
            end else begin
               cb_in = rd_data;
            end
         end
         ST_BRACKET: begin
            if (br_top_end) begin
               k_in = top_ff;
            end else if (br_bot_end) begin
               k_in = bot_ff;
            end else begin
               k_in    = top_ff;
               rem_in  = dividend[D_BITS-1:Q_BITS];
               quo_in  = dividend[Q_BITS-1:0];
               dvs_in  = {den, 1'b0};
               qcnt_in = QCNT_BITS'(Q_BITS - 1);
            end
         end
         ST_DIV: begin
            // restoring step, quotient bit shifts in behind the dividend bits
            rem_in  = alu_borrow ? alu_a[SAMPLE_BITS:0] : alu_diff[SAMPLE_BITS:0];
            quo_in  = {quo_ff[Q_BITS-2:0], !alu_borrow};
            qcnt_in = qcnt_ff - QCNT_BITS'(1);
         end
         ST_TEMP: begin
            if (rsp_free) begin
               rsp_temp_in   = temp_q;
               rsp_status_in = status_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      if (state_ff == ST_TEMP && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      last_ff       <= last_in;
      top_ff        <= top_in;
      bot_ff        <= bot_in;
      mid_ff        <= mid_in;
      ct_ff         <= ct_in;
      cb_ff         <= cb_in;
      k_ff          <= k_in;
      status_ff     <= status_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      quo_ff        <= quo_in;
      qcnt_ff       <= qcnt_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_status_ff <= rsp_status_in;
   end

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_temp_ff);
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   // probe index lies strictly inside the bracket
   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> ((top_ff < mid_ff) && (mid_ff < bot_ff)))
      else $error("search probe outside bracket");

   // the search ends on adjacent entries
   a_bracket_adjacent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BRACKET) |-> (bot_ff == top_ff + IDX_BITS'(1)))
      else $error("bracket not adjacent");

   // partial remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < dvs_ff))
      else $error("divide remainder out of range");

   // a finished conversion lands in the result slot and frees the block
   a_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEMP && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result handoff lost");
`endif

endmodule

FILE: verif/tb_top.sv
// testbench for the adc to temperature converter: table load, conversions and csr settings
`timescale 1ns / 1ps

module tb_top;
   import atb_pkg::*;

   localparam int REQ_BITS         = 32;
   localparam int RSP_BITS         = 24;
   localparam int ENTRY_COUNT      = TABLE_DEPTH_DEF;
   localparam int CODE_MAX         = (1 << SAMPLE_BITS_DEF) - 1;
   localparam int QUIET_CYCLES     = 40;      // longest convert latency plus margin
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int CYCLE_LIMIT      = 400000;

   typedef struct packed {
      logic [TEMP_BITS-1:0]   temperature_q;
      logic [STATUS_BITS-1:0] status;
   } reading_type;

   // dut ports, every input known from time zero
   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_BITS-1:0]      req_tdata   = '0;  // entry_index, entry_value, sample
   logic [0:0]               req_tuser   = '0;  // op
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_BITS-1:0]      rsp_tdata;         // temperature_q
   logic [STATUS_BITS-1:0]   rsp_tuser;         // status
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // our own view of the block: code table and the three settings
   logic [SAMPLE_BITS_DEF-1:0] adc_codes [ENTRY_COUNT];
   logic signed [BASE_BITS-1:0] base_deg  = BASE_BITS'(BASE_RESET);
   logic [STEP_BITS-1:0]        deg_step  = STEP_BITS'(STEP_RESET);
   logic [8:0]                  used_cfg  = 9'(USED_RESET);

   reading_type expected_readings[$];
   int       errors_seen  = 0;
   int       cycle_count  = 0;
   bit       send_idling  = 1'b1;
   bit       rsp_idling   = 1'b1;
   bit       hold_results = 1'b0;

   adc_to_temperature_bsearch dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run guard: a hang anywhere ends here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- prediction

   // entries_used clamps to 2 .. table depth
   function automatic int used_entries();
      int n;
      n = int'(used_cfg);
      if (n < 2) n = 2;
      if (n > ENTRY_COUNT) n = ENTRY_COUNT;
      return n;
   endfunction

   // temperature of entry k in sixteenths of a degree
   function automatic longint entry_temp_q(input int k);
      longint b;
      longint d;
      b = longint'(base_deg);
      d = longint'(deg_step);
      return (b + longint'(k) * d) * (longint'(1) << FRAC_BITS_DEF);
   endfunction

   function automatic reading_type predict_reading(input logic [SAMPLE_BITS_DEF-1:0] smp);
      int          n, s, top, bot, mid, c, ct, cb;
      bit          hit;
      longint      t, num, den;
      reading_type r;
      n        = used_entries();
      s        = int'(smp);
      hit      = 1'b0;
      t        = 0;
      r.status = STATUS_IN_TABLE;
      if (s > int'(adc_codes[0])) begin
         // colder than the first entry
         r.status = STATUS_COLD;
         t        = entry_temp_q(0);
      end else if (s < int'(adc_codes[n-1])) begin
         // hotter than the last used entry
         r.status = STATUS_HOT;
         t        = entry_temp_q(n - 1);
      end else begin
         top = 0;
         bot = n - 1;
         while (bot - top > 1 && !hit) begin
            mid = (top + bot) / 2;
            c   = int'(adc_codes[mid]);
            if (s < c) begin
               top = mid;
            end else if (s > c) begin
               bot = mid;
            end else begin
               hit = 1'b1;
               t   = entry_temp_q(mid);
            end
         end
         if (!hit) begin
            ct = int'(adc_codes[top]);
            cb = int'(adc_codes[bot]);
            if (s >= ct || ct <= cb) begin
               // bracket not falling or sample on the cold end
               t = entry_temp_q(top);
            end else if (s <= cb) begin
               t = entry_temp_q(bot);
            end else begin
               // fraction of a step, rounded half up, rising toward the hot entry
               num = longint'(ct - s) * longint'(deg_step) * (longint'(1) << FRAC_BITS_DEF);
               den = longint'(ct - cb);
               t   = entry_temp_q(top) + (2 * num + den) / (2 * den);
            end
         end
      end
      r.temperature_q = t[TEMP_BITS-1:0];
      return r;
   endfunction

   // --------------------------------------------------------------- result check

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            $error("result transaction with nothing expected: temperature_q %0d status %0d",
                   $signed(rsp_tdata[TEMP_BITS-1:0]), rsp_tuser);
            errors_seen++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_tdata[TEMP_BITS-1:0] !== want.temperature_q) begin
               $error("temperature_q expected %0d actual %0d",
                      $signed(want.temperature_q), $signed(rsp_tdata[TEMP_BITS-1:0]));
               errors_seen++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_tuser);
               errors_seen++;
            end
         end
      end
   end

   // receiver: random stall bursts, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------- driver tasks

   // one request transaction; expectation recorded at acceptance
   task automatic send_item(input logic op, input logic [7:0] idx,
                            input logic [SAMPLE_BITS_DEF-1:0] value,
                            input logic [SAMPLE_BITS_DEF-1:0] smp);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, smp, value, idx};
      do @(posedge clock); while (!req_tready);
      if (op == OP_CONVERT) begin
         expected_readings.push_back(predict_reading(smp));
      end else begin
         adc_codes[idx] = value;
      end
      if (send_idling && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // unused fields carry random bits
   task automatic write_entry(input int idx, input int value);
      send_item(OP_WRITE, idx[7:0], value[SAMPLE_BITS_DEF-1:0],
                SAMPLE_BITS_DEF'($urandom_range(0, CODE_MAX)));
   endtask

   task automatic convert(input int smp);
      send_item(OP_CONVERT, 8'($urandom_range(0, 255)),
                SAMPLE_BITS_DEF'($urandom_range(0, CODE_MAX)),
                smp[SAMPLE_BITS_DEF-1:0]);
   endtask

   // stop offering, wait for every result, then cover a write still in flight
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [REG_IDX_BITS-1:0] idx,
                             input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // write all three registers while idle and read each one back
   task automatic set_config(input logic [7:0] base, input logic [3:0] step,
                             input logic [8:0] used);
      logic [CSR_DATA_BITS-1:0] wvals [3];
      logic [CSR_DATA_BITS-1:0] masks [3];
      logic [REG_IDX_BITS-1:0]  regs  [3];
      logic [CSR_DATA_BITS-1:0] rdata;
      wait_for_quiet();
      regs  = '{REG_BASE, REG_STEP, REG_USED};
      wvals = '{{24'd0, base}, {28'd0, step}, {23'd0, used}};
      masks = '{32'h0ff, 32'h00f, 32'h1ff};
      for (int i = 0; i < 3; i++) begin
         csr_access(1'b1, regs[i], wvals[i], rdata);
         csr_access(1'b0, regs[i], '0, rdata);
         if (((rdata ^ wvals[i]) & masks[i]) != 0) begin
            $error("csr register %0d expected %0h actual %0h", regs[i],
                   wvals[i] & masks[i], rdata & masks[i]);
            errors_seen++;
         end
      end
      base_deg = base;
      deg_step = step;
      used_cfg = used;
   endtask

   // sample near the table: exact codes, inside brackets, past either end, or anywhere
   function automatic int pick_sample();
      int n, k, pick, hi, lo;
      n    = used_entries();
      k    = $urandom_range(0, n - 1);
      pick = $urandom_range(0, 9);
      hi   = int'(adc_codes[k]);
      lo   = (k < n - 1) ? int'(adc_codes[k+1]) : hi;
      if (pick < 3) return hi;
      if (pick < 7) return $urandom_range(lo, hi);
      if (pick == 7 && adc_codes[0] < CODE_MAX)
         return $urandom_range(int'(adc_codes[0]) + 1, CODE_MAX);
      if (pick == 8 && adc_codes[n-1] > 0)
         return $urandom_range(0, int'(adc_codes[n-1]) - 1);
      return $urandom_range(0, CODE_MAX);
   endfunction

   // mostly writes that keep the codes falling, a few that break the order
   task automatic random_write();
      int idx, lo, hi;
      idx = $urandom_range(0, ENTRY_COUNT - 1);
      hi  = (idx == 0) ? CODE_MAX : int'(adc_codes[idx-1]);
      lo  = (idx == ENTRY_COUNT - 1) ? 0 : int'(adc_codes[idx+1]);
      if ($urandom_range(0, 6) == 0) begin
         write_entry(idx, $urandom_range(0, CODE_MAX));
      end else begin
         write_entry(idx, $urandom_range(lo, hi));
      end
   endtask

   task automatic random_items(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 15) begin
            random_write();
         end else begin
            convert(pick_sample());
         end
      end
   endtask

   // --------------------------------------------------------------- test tasks

   // fill every entry with falling codes, small plateaus now and then
   task automatic test_table_load();
      int code;
      code = $urandom_range(900, 1020);
      for (int k = 0; k < ENTRY_COUNT; k++) begin
         write_entry(k, code);
         code = code - (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4));
         if (code < 0) code = 0;
      end
   endtask

   // directed cases under the reset settings
   task automatic test_directed();
      int n, keep0, keep85, keep86;
      n      = used_entries();
      keep0  = int'(adc_codes[0]);
      keep85 = int'(adc_codes[85]);
      keep86 = int'(adc_codes[86]);
      convert(CODE_MAX);                                   // saturated cold
      convert(0);                                          // saturated hot
      convert(int'(adc_codes[0]));                         // exact first entry
      convert(int'(adc_codes[n-1]));                       // exact last used entry
      convert((adc_codes[n-1] > 0) ? adc_codes[n-1] - 1 : 0);
      convert(int'(adc_codes[85]));                        // hit on the first probe
      convert(adc_codes[85] + 1);                          // interpolate 84 .. 85
      convert(adc_codes[0] - 1);                           // interpolate near the top
      convert(adc_codes[50] - 1);
      write_entry(0, CODE_MAX);                            // top code at full scale
      convert(CODE_MAX);
      write_entry(0, keep0);
      write_entry(85, int'(adc_codes[84]));                // flat bracket
      convert(int'(adc_codes[84]));
      convert((adc_codes[84] + adc_codes[86]) / 2);
      write_entry(86, (adc_codes[84] + 5 > CODE_MAX) ? CODE_MAX : adc_codes[84] + 5);
      convert(int'(adc_codes[84]));                        // rising bracket
      convert(adc_codes[87] + 1);
      write_entry(85, keep85);
      write_entry(86, keep86);
      write_entry(254, 1);                                 // bottom of the code range
      write_entry(255, 0);
   endtask

   task automatic test_random_phase(input logic [7:0] base, input logic [3:0] step,
                                    input logic [8:0] used, input int count);
      set_config(base, step, used);
      random_items(count);
   endtask

   // receiver holds for a long stretch while the sender keeps offering
   task automatic test_receiver_hold();
      send_idling  = 1'b0;
      hold_results = 1'b1;
      for (int i = 0; i < 30; i++) convert(pick_sample());
      send_idling  = 1'b1;
   endtask

   // sender pauses mid stream until every result is back
   task automatic test_sender_drain();
      random_items(25);
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      @(posedge clock);
      random_items(25);
   endtask

   // ----------------------------------------------------------------- sequence

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_load();
      test_directed();

      test_random_phase(8'd127, 4'd15, 9'd256, 80);        // hottest and widest
      test_random_phase(-8'sd128, 4'd15, 9'd2, 60);        // coldest, two entries
      set_config(-8'sd20, 4'd3, 9'd100);
      test_receiver_hold();
      test_sender_drain();
      test_random_phase(-8'sd128, 4'd0, 9'd256, 70);       // zero step

      test_table_load();                                   // fresh falling table
      test_random_phase(8'd10, 4'd2, 9'd1, 40);            // acts as two entries
      test_random_phase(-8'sd5, 4'd7, 9'd511, 70);         // acts as the full table
      for (int p = 0; p < 3; p++) begin
         test_random_phase(8'($urandom_range(0, 255)), 4'($urandom_range(1, 15)),
                           9'($urandom_range(2, 256)), 40);
      end

      // closing stretch with no idling on either side
      set_config(8'($urandom_range(0, 255)), 4'($urandom_range(1, 15)),
                 9'($urandom_range(2, 256)));
      send_idling = 1'b0;
      rsp_idling  = 1'b0;
      random_items(100);

      wait_for_quiet();
      if (errors_seen == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
